// File: rtl/rgb_block_average_pixelate_assert.svh
// Assertion macros used by the checker of the pixelation block.
`ifndef RGB_BLOCK_AVERAGE_PIXELATE_ASSERT_SVH
`define RGB_BLOCK_AVERAGE_PIXELATE_ASSERT_SVH

// Consequent is checked at the same edge as the antecedent.
`define RBAP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rbap: same-cycle check failed");

// Consequent is checked at the edge after the antecedent's.
`define RBAP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rbap: next-cycle check failed");

`endif

// File: rtl/rbap_pkg.sv
package rbap_pkg;

    // Defaults of the top-level parameters.
    localparam int DEF_TILE_SIZE = 8;
    localparam int DEF_MAX_WIDTH = 4096;

    // Fixed frame height limit and field widths.
    localparam int MAX_HEIGHT  = 4096;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CH_W        = 8;
    localparam int TILE_IDX_W  = 11;
    localparam int Y_W         = 12;
    localparam int DIV_STEP_W  = 3;

    // Stream payload widths.
    localparam int S_TDATA_W   = 24;
    localparam int M_FIELDS_W  = 2 * TILE_IDX_W + 3 * CH_W;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    // Register reset values.
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    // Mean divider states.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } div_state_t;

endpackage

// File: rtl/rgb_block_average_pixelate.sv
// A request that completes a tile passes the accumulate stage, mean divider and output register.
// Throughput: one pixel per cycle; a tile-completing pixel holds s_tready low from its
// accumulate stage until the one-bit-per-cycle mean divider (8 steps) hands its result over.
// Tile sums live in one memory of one entry per tile column, read-modify-write with forwarding.
// Reset (aresetn low, synchronous) restores 640 x 480 and the raster position to the origin;
// the sum memory needs no clearing pass, as each tile loads its entry on its first pixel.
module rgb_block_average_pixelate import rbap_pkg::*; #(
    parameter int TILE_SIZE = DEF_TILE_SIZE,
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // Pixel stream in.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in
    // Tile result stream out; tlast is frame_done.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // tile_row, tile_col, red, green, blue means, pad
    output logic                  m_tlast
);

    localparam int TILE_COLS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TC_W      = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
    localparam int X_W       = $clog2(MAX_WIDTH);
    localparam int WD_W      = X_W + 1;
    localparam int SUB_W     = $clog2(TILE_SIZE);
    localparam int SUM_W     = $clog2(TILE_SIZE * TILE_SIZE * ((1 << CH_W) - 1) + 1);
    localparam int CNT_W     = $clog2(TILE_SIZE * TILE_SIZE + 1);
    localparam int DSR_W     = CNT_W + CH_W - 1;
    localparam int CMP_W     = (SUM_W > DSR_W) ? SUM_W : DSR_W;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [CNT_W-1:0] count;
    } entry_t;

    // One restoring division step: subtract the shifted divisor where it fits.
    function automatic logic [SUM_W:0] div_step(input logic [SUM_W-1:0] rem,
                                                input logic [DSR_W-1:0] dsr);
        logic            fits;
        logic [CMP_W-1:0] diff;
        fits = CMP_W'(rem) >= CMP_W'(dsr);
        diff = CMP_W'(rem) - CMP_W'(dsr);
        return fits ? {1'b1, diff[SUM_W-1:0]} : {1'b0, rem};
    endfunction

    logic [CFG_W-1:0]       image_width_reg;
    logic [CFG_W-1:0]       image_height_reg;

    logic [X_W-1:0]         x_reg;
    logic [Y_W-1:0]         y_reg;
    logic [SUB_W-1:0]       xin_reg;
    logic [SUB_W-1:0]       yin_reg;
    logic [TC_W-1:0]        tc_reg;
    logic [TILE_IDX_W-1:0]  trow_reg;

    logic [CFG_W:0]         w_wide;
    logic [WD_W-1:0]        w_eff;
    logic [CFG_W-1:0]       h_eff;
    logic                   last_col;
    logic                   last_row;
    logic                   sub_x_end;
    logic                   sub_y_end;
    logic                   s_accept;

    logic                   s1_valid_reg;
    logic                   s1_load_reg;
    logic                   s1_tend_reg;
    logic                   s1_done_reg;
    logic [TC_W-1:0]        s1_tc_reg;
    logic [TILE_IDX_W-1:0]  s1_trow_reg;
    logic [CH_W-1:0]        s1_red_reg;
    logic [CH_W-1:0]        s1_green_reg;
    logic [CH_W-1:0]        s1_blue_reg;

    entry_t                 tile_mem [TILE_COLS];
    entry_t                 rd_reg;
    entry_t                 fwd_data_reg;
    logic                   fwd_hit_reg;
    entry_t                 acc_base;
    entry_t                 acc_next;

    div_state_t             div_state_reg;
    div_state_t             div_state_next;
    logic [DIV_STEP_W-1:0]  step_reg;
    logic [DSR_W-1:0]       dsr_reg;
    logic [SUM_W-1:0]       rem_red_reg;
    logic [SUM_W-1:0]       rem_green_reg;
    logic [SUM_W-1:0]       rem_blue_reg;
    logic [CH_W-1:0]        q_red_reg;
    logic [CH_W-1:0]        q_green_reg;
    logic [CH_W-1:0]        q_blue_reg;
    logic [TILE_IDX_W-1:0]  res_row_reg;
    logic [TILE_IDX_W-1:0]  res_col_reg;
    logic                   res_done_reg;
    logic [SUM_W:0]         step_red;
    logic [SUM_W:0]         step_green;
    logic [SUM_W:0]         step_blue;
    logic                   out_free;
    logic                   cfg_hit;

    logic                   m_tvalid_reg;
    logic [TILE_IDX_W-1:0]  m_row_reg;
    logic [TILE_IDX_W-1:0]  m_col_reg;
    logic [CH_W-1:0]        m_red_reg;
    logic [CH_W-1:0]        m_green_reg;
    logic [CH_W-1:0]        m_blue_reg;
    logic                   m_last_reg;

    // Effective frame size: zero acts as one, oversize is clipped.
    always_comb begin
        if (image_width_reg == '0) begin
            w_wide = (CFG_W + 1)'(1);
        end else if ({1'b0, image_width_reg} > (CFG_W + 1)'(MAX_WIDTH)) begin
            w_wide = (CFG_W + 1)'(MAX_WIDTH);
        end else begin
            w_wide = {1'b0, image_width_reg};
        end
        if (image_height_reg == '0) begin
            h_eff = CFG_W'(1);
        end else if (image_height_reg > CFG_W'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = image_height_reg;
        end
    end

    assign w_eff     = WD_W'(w_wide);
    assign last_col  = (WD_W'(x_reg) + WD_W'(1)) >= w_eff;
    assign last_row  = (CFG_W'(y_reg) + CFG_W'(1)) >= h_eff;
    assign sub_x_end = xin_reg == SUB_W'(TILE_SIZE - 1);
    assign sub_y_end = yin_reg == SUB_W'(TILE_SIZE - 1);

    // Input is taken while the divider is free and no tile end waits to start it.
    assign s_tready = (div_state_reg == DIV_IDLE) && !(s1_valid_reg && s1_tend_reg);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_hit  = cfg_we && ((cfg_index == CFG_IMAGE_WIDTH) ||
                                 (cfg_index == CFG_IMAGE_HEIGHT));

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
        end else if (cfg_we) begin
            if (cfg_index == CFG_IMAGE_WIDTH) begin
                image_width_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_IMAGE_HEIGHT) begin
                image_height_reg <= cfg_wdata;
            end
        end
    end

    // Raster position, kept also as tile index and offset within the tile.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            x_reg    <= '0;
            y_reg    <= '0;
            xin_reg  <= '0;
            yin_reg  <= '0;
            tc_reg   <= '0;
            trow_reg <= '0;
        end else if (s_accept) begin
            if (last_col) begin
                x_reg   <= '0;
                xin_reg <= '0;
                tc_reg  <= '0;
                if (last_row) begin
                    y_reg    <= '0;
                    yin_reg  <= '0;
                    trow_reg <= '0;
                end else begin
                    y_reg   <= y_reg + Y_W'(1);
                    yin_reg <= sub_y_end ? '0 : yin_reg + SUB_W'(1);
                    if (sub_y_end) begin
                        trow_reg <= trow_reg + TILE_IDX_W'(1);
                    end
                end
            end else begin
                x_reg   <= x_reg + X_W'(1);
                xin_reg <= sub_x_end ? '0 : xin_reg + SUB_W'(1);
                if (sub_x_end) begin
                    tc_reg <= tc_reg + TC_W'(1);
                end
            end
        end
    end

    // Accumulate stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            fwd_hit_reg  <= s_accept && s1_valid_reg && (s1_tc_reg == tc_reg);
        end
    end

    // Accumulate stage payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_load_reg  <= (xin_reg == '0) && (yin_reg == '0);
            s1_tend_reg  <= (last_col || sub_x_end) && (last_row || sub_y_end);
            s1_done_reg  <= last_col && last_row;
            s1_tc_reg    <= tc_reg;
            s1_trow_reg  <= trow_reg;
            s1_red_reg   <= s_tdata[CH_W-1:0];
            s1_green_reg <= s_tdata[2*CH_W-1:CH_W];
            s1_blue_reg  <= s_tdata[3*CH_W-1:2*CH_W];
        end
        if (s1_valid_reg) begin
            fwd_data_reg <= acc_next;
        end
    end

    // Tile column sum memory: read on acceptance, written back in the following cycle.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_reg <= tile_mem[tc_reg];
        end
        if (s1_valid_reg) begin
            tile_mem[s1_tc_reg] <= acc_next;
        end
    end

    // New sums: the first pixel of a tile loads, the others add.
    always_comb begin
        acc_base = fwd_hit_reg ? fwd_data_reg : rd_reg;
        if (s1_load_reg) begin
            acc_next.red   = SUM_W'(s1_red_reg);
            acc_next.green = SUM_W'(s1_green_reg);
            acc_next.blue  = SUM_W'(s1_blue_reg);
            acc_next.count = CNT_W'(1);
        end else begin
            acc_next.red   = acc_base.red + SUM_W'(s1_red_reg);
            acc_next.green = acc_base.green + SUM_W'(s1_green_reg);
            acc_next.blue  = acc_base.blue + SUM_W'(s1_blue_reg);
            acc_next.count = acc_base.count + CNT_W'(1);
        end
    end

    // Divider state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_state_reg <= DIV_IDLE;
        end else begin
            div_state_reg <= div_state_next;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Divider next state.
    always_comb begin
        div_state_next = div_state_reg;
        unique case (div_state_reg)
            DIV_IDLE: begin
                if (s1_valid_reg && s1_tend_reg) begin
                    div_state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (step_reg == '0) begin
                    div_state_next = DIV_HOLD;
                end
            end
            DIV_HOLD: begin
                if (out_free) begin
                    div_state_next = DIV_IDLE;
                end
            end
            default: begin
                div_state_next = DIV_IDLE;
            end
        endcase
    end

    assign step_red   = div_step(rem_red_reg, dsr_reg);
    assign step_green = div_step(rem_green_reg, dsr_reg);
    assign step_blue  = div_step(rem_blue_reg, dsr_reg);

    // Mean divider: one quotient bit per cycle for all three channels.
    always_ff @(posedge aclk) begin
        if (div_state_reg == DIV_IDLE && s1_valid_reg && s1_tend_reg) begin
            rem_red_reg   <= acc_next.red;
            rem_green_reg <= acc_next.green;
            rem_blue_reg  <= acc_next.blue;
            dsr_reg       <= {acc_next.count, {(CH_W - 1){1'b0}}};
            step_reg      <= DIV_STEP_W'(CH_W - 1);
            res_row_reg   <= s1_trow_reg;
            res_col_reg   <= TILE_IDX_W'(s1_tc_reg);
            res_done_reg  <= s1_done_reg;
        end else if (div_state_reg == DIV_RUN) begin
            rem_red_reg   <= step_red[SUM_W-1:0];
            rem_green_reg <= step_green[SUM_W-1:0];
            rem_blue_reg  <= step_blue[SUM_W-1:0];
            q_red_reg     <= {q_red_reg[CH_W-2:0], step_red[SUM_W]};
            q_green_reg   <= {q_green_reg[CH_W-2:0], step_green[SUM_W]};
            q_blue_reg    <= {q_blue_reg[CH_W-2:0], step_blue[SUM_W]};
            dsr_reg       <= dsr_reg >> 1;
            step_reg      <= step_reg - DIV_STEP_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (div_state_reg == DIV_HOLD && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_state_reg == DIV_HOLD && out_free) begin
            m_row_reg   <= res_row_reg;
            m_col_reg   <= res_col_reg;
            m_red_reg   <= q_red_reg;
            m_green_reg <= q_green_reg;
            m_blue_reg  <= q_blue_reg;
            m_last_reg  <= res_done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_blue_reg, m_green_reg, m_red_reg,
                       m_col_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/rbap_checker.sv
`include "rgb_block_average_pixelate_assert.svh"

module rbap_checker import rbap_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // A stalled result stays offered.
    `RBAP_ASSERT_NEXT(a_out_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // A stalled result keeps its payload.
    `RBAP_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

    // A fresh result comes only after the divider has held the input off.
    `RBAP_ASSERT_SAME(a_rise_after_div, aclk, aresetn, $rose(m_tvalid), !$past(s_tready) && !$past(s_tready, 2))

    // A result that follows a taken one directly was handed over while the input was held.
    `RBAP_ASSERT_NEXT(a_refill_held, aclk, aresetn, m_tvalid && m_tready, !m_tvalid || !$past(s_tready))

endmodule

bind rgb_block_average_pixelate rbap_checker u_rbap_checker (.*);
